// ===== design/serial_line_editor_assert.svh =====
// ----------------------------------------------------------------------------
// serial_line_editor assertion macros
// shorthand for clocked implication checks, gated by the active-low reset
// ----------------------------------------------------------------------------
`ifndef SERIAL_LINE_EDITOR_ASSERT_SVH
`define SERIAL_LINE_EDITOR_ASSERT_SVH

// same-cycle implication
`define SLE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("serial_line_editor check failed");

// next-cycle implication
`define SLE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("serial_line_editor check failed");

`endif

// ===== design/sle_pkg.sv =====
// ----------------------------------------------------------------------------
// sle_pkg
// shared types and constants of the serial line editor
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned LineLength = 64;
  localparam int unsigned StoreDepth = 64;
  localparam int unsigned AddrW      = $clog2(StoreDepth);
  localparam int unsigned CntW       = $clog2(LineLength + 1);
  localparam int unsigned QDepth     = 2;
  localparam int unsigned QPtrW      = $clog2(QDepth);
  localparam int unsigned QCntW      = $clog2(QDepth + 1);
  localparam int unsigned CfgIdxW    = 1;

  localparam logic [ByteW-1:0] CommitReset = 8'd13;
  localparam logic [ByteW-1:0] EraseReset  = 8'h7f;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgCommit = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgErase  = 1'b1;

  typedef enum logic [1:0] {
    CmdChar,
    CmdErase,
    CmdCommit
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e        kind;
    logic [ByteW-1:0] data;
  } cmd_t;

  typedef enum logic {
    BkIdle,
    BkEmit
  } back_state_e;

  typedef struct packed {
    logic            emitting;
    logic [CntW-1:0] count;
  } back_stat_t;

endpackage

// ===== design/sle_front.sv =====
// ----------------------------------------------------------------------------
// sle_front
// holds the control bytes and classifies each received byte into a command
// ----------------------------------------------------------------------------
module sle_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [sle_pkg::ByteW-1:0]   rx_byte_i,
  input  logic                        cfg_we_i,
  input  logic [sle_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [sle_pkg::ByteW-1:0]   cfg_data_i,
  input  logic                        q_full_i,
  output logic                        push_o,
  output sle_pkg::cmd_t               cmd_o
);
  import sle_pkg::*;

  logic [ByteW-1:0] commit_q;
  logic [ByteW-1:0] erase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      commit_q <= CommitReset;
      erase_q  <= EraseReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgCommit: commit_q <= cfg_data_i;
        CfgErase:  erase_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // commit wins when both control bytes match
  always_comb begin
    cmd_o.data = rx_byte_i;
    if (rx_byte_i == commit_q) begin
      cmd_o.kind = CmdCommit;
    end else if (rx_byte_i == erase_q) begin
      cmd_o.kind = CmdErase;
    end else begin
      cmd_o.kind = CmdChar;
    end
  end

  assign push_o = start_i & ~q_full_i;

endmodule

// ===== design/sle_queue.sv =====
// ----------------------------------------------------------------------------
// sle_queue
// short command queue between the front and back parts
// ----------------------------------------------------------------------------
module sle_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sle_pkg::cmd_t push_cmd_i,
  input  logic          pop_i,
  output sle_pkg::cmd_t head_o,
  output logic          full_o,
  output logic          empty_o
);
  import sle_pkg::*;

  cmd_t             entry_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign head_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ===== design/sle_back.sv =====
// ----------------------------------------------------------------------------
// sle_back
// executes queued commands on the line store and streams committed lines
// ----------------------------------------------------------------------------
module sle_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sle_pkg::cmd_t             head_i,
  input  logic                      q_empty_i,
  output logic                      pop_o,
  output logic                      result_valid_o,
  output logic [sle_pkg::ByteW-1:0] line_char_o,
  output logic                      last_char_o,
  output logic                      empty_line_o,
  output sle_pkg::back_stat_t       stat_o
);
  import sle_pkg::*;

  back_state_e      state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]  len_q, len_d;
  logic [AddrW-1:0] rd_idx_q, rd_idx_d;
  logic             out_v_q, out_v_d;
  logic             out_last_q, out_last_d;
  logic             out_empty_q, out_empty_d;
  logic             we;
  logic             at_last;
  logic [ByteW-1:0] store_q [StoreDepth];
  logic [ByteW-1:0] rd_data_q;

  assign at_last = ((CntW'(rd_idx_q) + CntW'(1)) == len_q);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    len_d       = len_q;
    rd_idx_d    = rd_idx_q;
    out_v_d     = 1'b0;
    out_last_d  = 1'b0;
    out_empty_d = 1'b0;
    pop_o       = 1'b0;
    we          = 1'b0;
    case (state_q)
      BkIdle: begin
        if (!q_empty_i) begin
          pop_o = 1'b1;
          case (head_i.kind)
            CmdChar: begin
              if (cnt_q < CntW'(LineLength)) begin
                we    = 1'b1;
                cnt_d = cnt_q + CntW'(1);
              end
            end
            CmdErase: begin
              if (cnt_q != '0) begin
                cnt_d = cnt_q - CntW'(1);
              end
            end
            CmdCommit: begin
              cnt_d = '0;
              if (cnt_q == '0) begin
                out_v_d     = 1'b1;
                out_last_d  = 1'b1;
                out_empty_d = 1'b1;
              end else begin
                len_d    = cnt_q;
                rd_idx_d = '0;
                state_d  = BkEmit;
              end
            end
            default: ;
          endcase
        end
      end
      BkEmit: begin
        // one store read per cycle, result shows up with the read data
        out_v_d    = 1'b1;
        out_last_d = at_last;
        if (at_last) begin
          state_d = BkIdle;
        end else begin
          rd_idx_d = rd_idx_q + AddrW'(1);
        end
      end
      default: state_d = BkIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      cnt_q       <= '0;
      out_v_q     <= 1'b0;
      out_last_q  <= 1'b0;
      out_empty_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_v_q     <= out_v_d;
      out_last_q  <= out_last_d;
      out_empty_q <= out_empty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q    <= len_d;
    rd_idx_q <= rd_idx_d;
  end

  // line store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      store_q[cnt_q[AddrW-1:0]] <= head_i.data;
    end
    rd_data_q <= store_q[rd_idx_q];
  end

  assign result_valid_o  = out_v_q;
  assign last_char_o     = out_last_q;
  assign empty_line_o    = out_empty_q;
  assign line_char_o     = out_empty_q ? '0 : rd_data_q;
  assign stat_o.emitting = (state_q == BkEmit);
  assign stat_o.count    = cnt_q;

endmodule

// ===== design/serial_line_editor.sv =====
// ----------------------------------------------------------------------------
// serial_line_editor
// line editor with erase for a received serial byte stream
// ----------------------------------------------------------------------------
// usage
// - request channel: rx_byte_i is taken at a rising edge with start_i high and
//   busy_o low; busy_o is high only while the command queue is full
// - config port: cfg_we_i writes cfg_data_i to register cfg_idx_i at the edge
//   (0 = commit byte, reset 13; 1 = erase byte, reset 0x7f); write only when
//   the block is idle
// - result channel: result_valid_o marks one result per cycle; there is no
//   backpressure, every strobed cycle is a delivered result
// - an accepted request sits in the queue on the next cycle, and an idle back
//   end picks it up in that cycle
// - ordinary bytes and erase bytes give no result and leave the back end idle
// - a commit of n characters gives n results on consecutive cycles, after the
//   emit state and the registered store read; last one marked by last_char_o
// - a commit of an empty line gives a single result with line_char_o zero and
//   last_char_o and empty_line_o high, in the cycle after pickup
// - a commit keeps the back end busy for the pickup and then one store read per
//   character on the single read port; requests keep queuing in the two-entry
//   queue meanwhile
// - reset clears the character count and the queue and returns the control
//   bytes to their defaults; the line store itself has no reset and is only
//   read below the count
// ----------------------------------------------------------------------------
module serial_line_editor (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [sle_pkg::ByteW-1:0]   rx_byte_i,
  input  logic                        cfg_we_i,
  input  logic [sle_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [sle_pkg::ByteW-1:0]   cfg_data_i,
  output logic                        result_valid_o,
  output logic [sle_pkg::ByteW-1:0]   line_char_o,
  output logic                        last_char_o,
  output logic                        empty_line_o
);
  import sle_pkg::*;

  `include "serial_line_editor_assert.svh"

  // front to queue
  logic       push;
  cmd_t       push_cmd;
  // queue to back
  cmd_t       head;
  logic       q_full;
  logic       q_empty;
  logic       pop;
  back_stat_t stat;

  // front: control byte registers and classification
  sle_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .rx_byte_i  (rx_byte_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  // decoupling queue
  sle_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head),
    .full_o     (q_full),
    .empty_o    (q_empty)
  );

  // back: line store update and line streaming
  sle_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .q_empty_i      (q_empty),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .line_char_o    (line_char_o),
    .last_char_o    (last_char_o),
    .empty_line_o   (empty_line_o),
    .stat_o         (stat)
  );

  assign busy_o = q_full;

  // accepted request is in the queue on the next cycle
  `SLE_ASSERT_NXT(a_push_lands, start_i && !busy_o, !q_empty)
  // every streaming cycle yields a result in the following cycle
  `SLE_ASSERT_NXT(a_emit_strobes, stat.emitting, result_valid_o)
  // an empty line result is always the end of its line
  `SLE_ASSERT_IMP(a_empty_is_last, result_valid_o && empty_line_o, last_char_o)
  // count never exceeds the line length
  `SLE_ASSERT_IMP(a_count_bound, 1'b1, stat.count <= CntW'(LineLength))

endmodule
